@@ hdl/chte_pkg.sv @@
// Shared codes and types of the chained hash table engine.
`default_nettype none
package chte_pkg;

  // Operation codes; any other code behaves as a lookup
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Outcome of one operation on a bucket row
  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic       wr_en;
    logic       rd_data;
  } chte_res_t;

endpackage
`default_nettype wire

@@ hdl/chte_row_mem.sv @@
// Bucket row memory: one write port, one read port with registered data.
`default_nettype none
module chte_row_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 260
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write the row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the row; hold data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ hdl/chte_mod_unit.sv @@
// Bucket index unit: key modulo BUCKETS, a mask or four key bits per cycle.
`default_nettype none
module chte_mod_unit #(
  parameter int BUCKETS  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [KEY_BITS-1:0]        key,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] rem
);

  localparam int RW  = $clog2(BUCKETS);
  localparam int NCH = (KEY_BITS + 3) / 4;

  // Weight of each key bit reduced modulo BUCKETS, zero past the key
  function automatic logic [NCH*4*RW-1:0] bit_weights();
    logic [NCH*4*RW-1:0] tab;
    int                  r;
    tab = '0;
    r   = 1;
    for (int k = 0; k < KEY_BITS; k++) begin
      tab[k*RW +: RW] = RW'(r);
      r = (2 * r) % BUCKETS;
    end
    return tab;
  endfunction

  if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
    logic          done_r;
    logic [RW-1:0] rem_r;

    // Take the low key bits
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
      if (start) begin
        rem_r <= RW'(key);
      end
    end

    assign done = done_r;
    assign rem  = rem_r;
  end else begin : g_chunk
    localparam int SHW = NCH * 4;
    localparam int CW  = $clog2(NCH);
    localparam int SW  = RW + 3;
    localparam logic [NCH*4*RW-1:0] WTAB = bit_weights();
    localparam logic [SW-1:0] B1 = SW'(BUCKETS);
    localparam logic [SW-1:0] B2 = SW'(2 * BUCKETS);
    localparam logic [SW-1:0] B4 = SW'(4 * BUCKETS);

    logic           done_r;
    logic           busy_r;
    logic [CW-1:0]  cnt_r;
    logic [SHW-1:0] shreg_r;
    logic [RW-1:0]  acc_r;
    logic [SW-1:0]  sum;

    // Add the weights of the next four key bits, then fold back below BUCKETS
    always_comb begin
      sum = SW'(acc_r);
      for (int j = 0; j < 4; j++) begin
        if (shreg_r[j]) begin
          sum = sum + SW'(WTAB[(int'(cnt_r) * 4 + j) * RW +: RW]);
        end
      end
      if (sum >= B4) begin
        sum = sum - B4;
      end
      if (sum >= B2) begin
        sum = sum - B2;
      end
      if (sum >= B1) begin
        sum = sum - B1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
        busy_r <= 1'b0;
      end else begin
        done_r <= 1'b0;
        if (start) begin
          busy_r <= 1'b1;
        end else if (busy_r && cnt_r == CW'(NCH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
      if (start) begin
        shreg_r <= SHW'(key);
        acc_r   <= '0;
        cnt_r   <= '0;
      end else if (busy_r) begin
        shreg_r <= shreg_r >> 4;
        acc_r   <= sum[RW-1:0];
        cnt_r   <= cnt_r + 1'b1;
      end
    end

    assign done = done_r;
    assign rem  = acc_r;
  end

endmodule
`default_nettype wire

@@ hdl/chte_bucket_logic.sv @@
// Bucket update: compare all ways, choose hit or free way, build the new row.
`default_nettype none
module chte_bucket_logic #(
  parameter int WAYS       = 4,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic [1:0]                                op,
  input  logic [KEY_BITS-1:0]                       key,
  input  logic [VALUE_BITS-1:0]                     value,
  input  logic [WAYS*(1+KEY_BITS+VALUE_BITS)-1:0]   row_rd,
  output logic [WAYS*(1+KEY_BITS+VALUE_BITS)-1:0]   row_wr,
  output logic [VALUE_BITS-1:0]                     hit_value,
  output chte_pkg::chte_res_t                       res
);

  // Entry layout, low to high: value, key, valid
  localparam int EW = 1 + KEY_BITS + VALUE_BITS;

  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] free_vec;
  logic            seen;
  logic            found;
  logic            any_free;

  // Compare the ways and pick the lowest free one
  always_comb begin
    hit_value = '0;
    seen      = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = row_rd[w*EW + EW - 1] &&
                    (row_rd[w*EW + VALUE_BITS +: KEY_BITS] == key);
      free_vec[w] = !row_rd[w*EW + EW - 1] && !seen;
      if (!row_rd[w*EW + EW - 1]) begin
        seen = 1'b1;
      end
      if (hit_vec[w]) begin
        hit_value = hit_value | row_rd[w*EW +: VALUE_BITS];
      end
    end
    found    = |hit_vec;
    any_free = seen;
  end

  // Apply the operation to the row
  always_comb begin
    row_wr      = row_rd;
    res.found   = found;
    res.wr_en   = 1'b0;
    res.rd_data = 1'b0;
    res.status  = chte_pkg::ST_OK;
    case (op)
      chte_pkg::OP_INSERT: begin
        if (found) begin
          res.wr_en = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (hit_vec[w]) begin
              row_wr[w*EW +: VALUE_BITS] = value;
            end
          end
        end else if (any_free) begin
          res.wr_en = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (free_vec[w]) begin
              row_wr[w*EW +: EW] = {1'b1, key, value};
            end
          end
        end else begin
          res.status = chte_pkg::ST_FULL;
        end
      end
      chte_pkg::OP_REMOVE: begin
        if (found) begin
          res.wr_en = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (hit_vec[w]) begin
              row_wr[w*EW + EW - 1] = 1'b0;
            end
          end
        end else begin
          res.status = chte_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        // Lookup, and the unused code
        res.rd_data = found;
        if (!found) begin
          res.status = chte_pkg::ST_NOT_FOUND;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/chained_hash_table_engine_unit.sv @@
// Top level of the chained hash table engine.
// Key/value store of BUCKETS buckets with WAYS slots each; the bucket is the
// key modulo BUCKETS, and each bucket is one row of a single-port-read memory.
// After reset a clearing pass writes every row empty, during which no
// transaction is taken. One operation is worked at a time, through index,
// row read, compare and write back before the next accept; when BUCKETS is
// not a power of two the bucket index is reduced four key bits per cycle
// from a table of bit weights. The result sits in an output register, so a
// stalled result does not stop the next item from being accepted and worked
// up to write back.
`default_nettype none
module chained_hash_table_engine_unit #(
  parameter int BUCKETS    = 16,
  parameter int WAYS       = 4,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [31:0] out_data_out
);

  localparam int ROW_BITS = WAYS * (1 + KEY_BITS + VALUE_BITS);
  localparam int BKT_W    = $clog2(BUCKETS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_EXEC
  } state_t;

  state_t                  state_r;
  logic [BKT_W-1:0]        clr_idx_r;
  logic [1:0]              op_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [VALUE_BITS-1:0]   val_r;
  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic                    out_found_r;
  logic [31:0]             out_data_r;

  logic                    in_acc;
  logic                    commit;
  logic                    mod_done;
  logic [BKT_W-1:0]        bkt;
  logic                    mem_wr_en;
  logic [BKT_W-1:0]        mem_wr_addr;
  logic [ROW_BITS-1:0]     mem_wr_data;
  logic                    mem_rd_en;
  logic [ROW_BITS-1:0]     row_rd;
  logic [ROW_BITS-1:0]     row_wr;
  logic [VALUE_BITS-1:0]   hit_value;
  chte_pkg::chte_res_t     res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign commit    = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign mem_rd_en = (state_r == S_HASH) && mod_done;

  // Select the write source: clearing pass or operation write back
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_idx_r;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = commit && res.wr_en;
      mem_wr_addr = bkt;
      mem_wr_data = row_wr;
    end
  end

  chte_mod_unit #(
    .BUCKETS  (BUCKETS),
    .KEY_BITS (KEY_BITS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .key   (KEY_BITS'(in_key)),
    .done  (mod_done),
    .rem   (bkt)
  );

  chte_row_mem #(
    .DEPTH (BUCKETS),
    .WIDTH (ROW_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (bkt),
    .rd_data (row_rd)
  );

  chte_bucket_logic #(
    .WAYS       (WAYS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_bucket (
    .op        (op_r),
    .key       (key_r),
    .value     (val_r),
    .row_rd    (row_rd),
    .row_wr    (row_wr),
    .hit_value (hit_value),
    .res       (res)
  );

  // Sequence clear, accept, index, read and write back; hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == BKT_W'(BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      op_r  <= in_opcode;
      key_r <= KEY_BITS'(in_key);
      val_r <= VALUE_BITS'(in_data_in);
    end
    if (commit) begin
      out_status_r <= res.status;
      out_found_r  <= res.found;
      out_data_r   <= res.rd_data ? 32'(hit_value) : 32'd0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found    = out_found_r;
  assign out_data_out = out_data_r;

endmodule
`default_nettype wire

@@ hdl/chte_checker.sv @@
// Port checker for the chained hash table engine, bound to the top level.
`default_nettype none
module chte_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_status,
  input wire        out_found,
  input wire [31:0] out_data_out
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_found) && $stable(out_data_out))
    else $error("result changed while stalled");

  // One operation in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an operation is in work");

  // A key present before the operation always gives ok
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == chte_pkg::ST_OK)
    else $error("found key with a failing status");

  // Data only comes from a found key
  a_data_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_out != 32'd0 |-> out_found)
    else $error("data returned for a missing key");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == chte_pkg::ST_OK ||
    out_status == chte_pkg::ST_NOT_FOUND || out_status == chte_pkg::ST_FULL)
    else $error("undefined status code");

endmodule

bind chained_hash_table_engine_unit chte_checker u_chte_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_found    (out_found),
  .out_data_out (out_data_out)
);
`default_nettype wire
